FILE: design/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, codes and the character map of the base64 / base64url decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

    // Character code: 0..63 sextet value, then pad and foreign
    localparam logic [6:0] CODE_PAD = 7'd64;
    localparam logic [6:0] CODE_BAD = 7'd65;

    localparam logic [7:0] CHAR_PAD   = 8'h3D; // '='
    localparam logic [7:0] CHAR_PLUS  = 8'h2B; // '+'
    localparam logic [7:0] CHAR_MINUS = 8'h2D; // '-'
    localparam logic [7:0] CHAR_SLASH = 8'h2F; // '/'
    localparam logic [7:0] CHAR_UNDER = 8'h5F; // '_'

    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_SECOND = 2'd1;
    localparam logic [1:0] POS_THIRD  = 2'd2;
    localparam logic [1:0] POS_FOURTH = 2'd3;

    typedef struct packed {
        logic [7:0] in_char;
        logic       last_char;
    } b64d_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       string_done;
        logic       decode_error;
    } b64d_out_t;

    // Results that one character produces
    typedef struct packed {
        logic       byte_ok;
        logic [7:0] byte_val;
        logic       end_ok;
        logic       err;
    } b64d_res_t;

    function automatic logic [6:0] b64d_classify(input logic [7:0] c);
        logic [6:0] code;
        code = CODE_BAD;
        if (c inside {[8'h41:8'h5A]}) begin
            code = 7'(c - 8'h41);
        end else if (c inside {[8'h61:8'h7A]}) begin
            code = 7'(c - 8'h61 + 8'd26);
        end else if (c inside {[8'h30:8'h39]}) begin
            code = 7'(c - 8'h30 + 8'd52);
        end else if (c inside {CHAR_PLUS, CHAR_MINUS}) begin
            code = 7'd62;
        end else if (c inside {CHAR_SLASH, CHAR_UNDER}) begin
            code = 7'd63;
        end else if (c == CHAR_PAD) begin
            code = CODE_PAD;
        end
        return code;
    endfunction

endpackage

FILE: design/b64d_decode.sv
// ----------------------------------------------------------------------------
// b64d_decode
// Group state and per-character decode: maps one character, assembles the
// byte it completes and tracks position, pad and sticky error per string.
// ----------------------------------------------------------------------------
module b64d_decode (
    input  logic                aclk,
    input  logic                aresetn,
    input  b64d_pkg::b64d_in_t  item,
    input  logic                take,
    output b64d_pkg::b64d_res_t res
);
    import b64d_pkg::*;

    logic [1:0] pos_reg,   pos_next;
    logic [5:0] prev_reg,  prev_next;
    logic       third_pad_reg, third_pad_next;
    logic       err_reg,   err_next;

    logic [6:0] code;
    logic [5:0] v;
    logic       is_pad;
    logic       is_bad;
    logic       err_now;
    logic       have_byte;
    logic [7:0] byte_val;

    always_comb begin
        code      = b64d_classify(item.in_char);
        is_pad    = (code == CODE_PAD);
        is_bad    = (code == CODE_BAD);
        v         = code[6] ? 6'd0 : code[5:0];
        err_now   = err_reg | is_bad |
                    (is_pad & (pos_reg inside {POS_FIRST, POS_SECOND}));
        have_byte = 1'b0;
        byte_val  = 8'd0;
        third_pad_next = third_pad_reg;
        case (pos_reg)
            POS_SECOND: begin
                byte_val  = {prev_reg, v[5:4]};
                have_byte = !is_pad;
            end
            POS_THIRD: begin
                byte_val  = {prev_reg[3:0], v[5:2]};
                have_byte = !is_pad;
                if (is_pad) begin
                    third_pad_next = 1'b1;
                end
            end
            POS_FOURTH: begin
                byte_val       = {prev_reg[1:0], v};
                have_byte      = !third_pad_reg && !is_pad;
                third_pad_next = 1'b0;
            end
            default: begin
            end
        endcase

        res.byte_ok  = have_byte & !err_now;
        res.byte_val = byte_val;
        res.end_ok   = item.last_char;
        // lone final character is an error too
        res.err      = err_now | (pos_reg == POS_FIRST);

        pos_next  = pos_reg;
        prev_next = prev_reg;
        err_next  = err_reg;
        if (take) begin
            if (item.last_char) begin
                pos_next       = POS_FIRST;
                prev_next      = 6'd0;
                third_pad_next = 1'b0;
                err_next       = 1'b0;
            end else begin
                pos_next  = pos_reg + 2'd1;
                prev_next = v;
                err_next  = err_now;
            end
        end else begin
            third_pad_next = third_pad_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= POS_FIRST;
            prev_reg      <= 6'd0;
            third_pad_reg <= 1'b0;
            err_reg       <= 1'b0;
        end else begin
            pos_reg       <= pos_next;
            prev_reg      <= prev_next;
            third_pad_reg <= third_pad_next;
            err_reg       <= err_next;
        end
    end

endmodule

FILE: design/base64url_decoder.sv
// ----------------------------------------------------------------------------
// base64url_decoder
// Streaming base64 / base64url decoder, one character per beat.
// ----------------------------------------------------------------------------
// One character is accepted per cycle into an input register while s_ready
// is high; the decode of that character and its group state update are
// combinational from the input register into the result register.
// A character yields at most one byte beat, and the last character of a
// string adds an end beat carrying the error flag. The result channel
// carries one beat per cycle while m_ready is high, so sustained rate is one
// character per cycle except on a string's last character that also completes
// a byte, which needs a second beat on the result port before the next moves.
module base64url_decoder (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  b64d_pkg::b64d_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output b64d_pkg::b64d_out_t m_data
);
    import b64d_pkg::*;

    b64d_in_t   in_reg;
    logic       in_valid_reg, in_valid_next;
    logic       byte_pend_reg, byte_pend_next;
    logic       end_pend_reg,  end_pend_next;
    logic [7:0] byte_reg;
    logic       err_reg;
    logic       res_free;
    logic       move;
    b64d_res_t  res;

    b64d_decode u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .item    (in_reg),
        .take    (move),
        .res     (res)
    );

    always_comb begin
        m_valid = byte_pend_reg | end_pend_reg;
        if (byte_pend_reg) begin
            m_data = '{out_byte: byte_reg, byte_valid: 1'b1,
                       string_done: 1'b0, decode_error: 1'b0};
        end else begin
            m_data = '{out_byte: 8'd0, byte_valid: 1'b0,
                       string_done: 1'b1, decode_error: err_reg};
        end
        // result stage frees up when at most its final beat leaves now
        res_free = !m_valid || (m_ready && !(byte_pend_reg && end_pend_reg));
        move     = in_valid_reg && res_free;
        s_ready  = !in_valid_reg || move;

        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (move) begin
            in_valid_next = 1'b0;
        end

        byte_pend_next = byte_pend_reg;
        end_pend_next  = end_pend_reg;
        if (move) begin
            byte_pend_next = res.byte_ok;
            end_pend_next  = res.end_ok;
        end else if (m_valid && m_ready) begin
            // drop the beat just taken: byte goes first
            if (byte_pend_reg) begin
                byte_pend_next = 1'b0;
            end else begin
                end_pend_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            byte_pend_reg <= 1'b0;
            end_pend_reg  <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            byte_pend_reg <= byte_pend_next;
            end_pend_reg  <= end_pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (move) begin
            byte_reg <= res.byte_val;
            err_reg  <= res.err;
        end
    end

    a_beat_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.byte_valid != m_data.string_done))
        else $error("result beat is neither a byte nor an end beat");

    a_err_on_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.decode_error) |-> m_data.string_done)
        else $error("error flag on a byte beat");

    a_stall_held: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && m_valid))
        else $error("input stalled with no pending work");

    a_end_after_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (byte_pend_reg && end_pend_reg && m_ready) |=> (end_pend_reg && !byte_pend_reg))
        else $error("end beat lost behind its byte beat");

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Streams base64 and base64url strings, one character per beat, into the
// decoder with random gaps on both channels and one long hold-off on the
// result side. Each accepted character is decoded in a local predictor, and
// every result beat is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import b64d_pkg::*;

    logic      aclk;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    b64d_in_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    b64d_out_t m_data;

    base64url_decoder dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    string alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    b64d_in_t  pending_chars[$];
    b64d_out_t predicted_out[$];

    // Predictor state, one string at a time
    logic [1:0]  group_pos  = POS_FIRST;
    logic [17:0] held       = '0;
    logic        pad_third  = 1'b0;
    logic        string_bad = 1'b0;

    int chars_taken   = 0;
    int results_taken = 0;
    int mismatches    = 0;
    int hold_left     = 0;
    bit hold_done     = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [6:0] sextet_of(logic [7:0] c);
        logic [6:0] code;
        code = CODE_BAD;
        for (int i = 0; i < 64; i++) begin
            if (alphabet[i] == c) begin
                code = 7'(i);
            end
        end
        if (c == CHAR_MINUS) begin
            code = 7'd62;
        end
        if (c == CHAR_UNDER) begin
            code = 7'd63;
        end
        if (c == CHAR_PAD) begin
            code = CODE_PAD;
        end
        return code;
    endfunction

    function automatic void decode_char(b64d_in_t beat);
        logic [6:0] code;
        logic [5:0] sextet;
        logic [5:0] prev;
        logic [1:0] pos;
        logic       is_pad;
        logic       have_byte;
        logic [7:0] value;
        code      = sextet_of(beat.in_char);
        pos       = group_pos;
        is_pad    = (code == CODE_PAD);
        sextet    = (code < CODE_PAD) ? code[5:0] : 6'd0;
        prev      = held[5:0];
        have_byte = 1'b0;
        value     = 8'd0;
        if (code == CODE_BAD || (is_pad && pos < POS_THIRD)) begin
            string_bad = 1'b1;
        end
        case (pos)
            POS_SECOND: begin
                value     = {prev, sextet[5:4]};
                have_byte = !is_pad;
            end
            POS_THIRD: begin
                if (is_pad) begin
                    pad_third = 1'b1;
                end else begin
                    value     = {prev[3:0], sextet[5:2]};
                    have_byte = 1'b1;
                end
            end
            POS_FOURTH: begin
                // after a pad in third place the fourth character only gets checked
                if (!pad_third && !is_pad) begin
                    value     = {prev[1:0], sextet};
                    have_byte = 1'b1;
                end
                pad_third = 1'b0;
            end
            default: ;
        endcase
        held      = {held[11:0], sextet};
        group_pos = pos + 2'd1;
        if (have_byte && !string_bad) begin
            predicted_out.push_back({value, 1'b1, 1'b0, 1'b0});
        end
        if (beat.last_char) begin
            // a lone character in the final group cannot form a byte
            if (pos == POS_FIRST) begin
                string_bad = 1'b1;
            end
            predicted_out.push_back({8'd0, 1'b0, 1'b1, string_bad});
            group_pos  = POS_FIRST;
            held       = '0;
            pad_third  = 1'b0;
            string_bad = 1'b0;
        end
    endfunction

    function automatic logic [7:0] random_symbol();
        int pick;
        pick = $urandom_range(0, 65);
        if (pick == 64) begin
            return CHAR_MINUS;
        end
        if (pick == 65) begin
            return CHAR_UNDER;
        end
        return alphabet[pick];
    endfunction

    task automatic add_char(logic [7:0] c, logic last);
        b64d_in_t beat;
        beat.in_char   = c;
        beat.last_char = last;
        pending_chars.push_back(beat);
    endtask

    task automatic add_string(string text);
        for (int i = 0; i < text.len(); i++) begin
            add_char(text[i], i == text.len() - 1);
        end
    endtask

    task automatic add_random_string(output int count);
        logic [7:0] chars[$];
        int groups;
        int tail;
        int shape;
        int pick;
        groups = $urandom_range(0, 3);
        for (int g = 0; g < groups; g++) begin
            for (int k = 0; k < 4; k++) begin
                chars.push_back(random_symbol());
            end
            shape = $urandom_range(0, 3);
            if (shape == 0) begin
                chars[$] = CHAR_PAD;
            end else if (shape == 1) begin
                chars[$]     = CHAR_PAD;
                chars[$ - 1] = CHAR_PAD;
            end
        end
        pick = $urandom_range(0, 9);
        tail = (pick < 4) ? 0 : (pick == 4) ? 1 : (pick < 8) ? 2 : 3;
        if (groups == 0 && tail == 0) begin
            tail = 2;
        end
        for (int k = 0; k < tail; k++) begin
            chars.push_back(random_symbol());
        end
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            // raw noise: any byte anywhere
            foreach (chars[i]) begin
                chars[i] = 8'($urandom_range(0, 255));
            end
        end else if (pick < 3) begin
            chars[$urandom_range(0, chars.size() - 1)] = 8'($urandom_range(0, 255));
        end else if (pick == 3) begin
            chars[$urandom_range(0, chars.size() - 1)] = CHAR_PAD;
        end
        foreach (chars[i]) begin
            add_char(chars[i], i == chars.size() - 1);
        end
        count = chars.size();
    endtask

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Driver: hold the beat until it is taken, then offer the next one
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (pending_chars.size() != 0 &&
                ((chars_taken >= 100 && chars_taken < 160) ||
                 $urandom_range(0, 99) >= 27)) begin
                s_valid <= 1'b1;
                s_data  <= pending_chars.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result side ready, with one long hold-off to back the block up
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (!hold_done && chars_taken >= 40) begin
            hold_left <= 80;
            hold_done <= 1'b1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= (results_taken >= 80 && results_taken < 150) ||
                       $urandom_range(0, 99) >= 27;
        end
    end

    // Monitor: check the result beat first, then predict the accepted character
    always @(posedge aclk) begin
        b64d_out_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                results_taken <= results_taken + 1;
                if (predicted_out.size() == 0) begin
                    $display("%0t: no result expected, actual %p", $time, m_data);
                    mismatches++;
                end else begin
                    want = predicted_out.pop_front();
                    check_field("out_byte", want.out_byte, m_data.out_byte);
                    check_field("byte_valid", 8'(want.byte_valid),
                                8'(m_data.byte_valid));
                    check_field("string_done", 8'(want.string_done),
                                8'(m_data.string_done));
                    check_field("decode_error", 8'(want.decode_error),
                                8'(m_data.decode_error));
                end
            end
            if (s_valid && s_ready) begin
                chars_taken <= chars_taken + 1;
                decode_char(s_data);
            end
        end
    end

    initial begin
        int random_chars;
        int count;
        random_chars = 0;
        // pad in third place, pad inside the string, standard alphabet, partial of three
        add_string("Z+==/m8");
        // URL alphabet, pad in fourth place, partial of two
        add_string("-_A=Zg");
        // lone final character
        add_string("Q");
        // pad first, also the last of its string
        add_string("=");
        // early pad in second place, then nothing more may come out
        add_string("Q=Zg");
        add_char(8'h00, 1'b0);
        add_char("A", 1'b1);
        add_char(8'hFF, 1'b1);
        while (random_chars < 200) begin
            add_random_string(count);
            random_chars += count;
        end
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        do @(negedge aclk); while (pending_chars.size() != 0 || s_valid);
        do @(negedge aclk); while (predicted_out.size() != 0);
        repeat (20) @(negedge aclk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #1ms;
        $display("Mismatches found");
        $finish;
    end

endmodule
